@@ src/teq_pkg.sv @@
// Shared types and constants for the timestamp event queue.
package teq_pkg;

  localparam int unsigned QueueDepthDef  = 64;
  localparam int unsigned PayloadBitsDef = 32;
  localparam int unsigned StampW         = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_PAST_END = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage

@@ src/timestamp_event_queue.sv @@
// Top level of the timestamp event queue: sorted register chain plus result register.
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries kind_i, stamp_i, payload_i.
//   kind 0 schedules an event, kind 1 removes the earliest event.
//   Every transaction yields exactly one result on the output channel
//   (res_valid_o / res_ready_i): status, out_valid, out_stamp, out_payload,
//   now_time and fill.
//   The result is registered: it appears the cycle after acceptance.
//   Throughput is one transaction per cycle while the receiver takes each
//   result; every cell of the chain compares against the new stamp and
//   shifts in the same cycle.
//   When the receiver stalls, the result register holds and in_ready_o drops
//   until the result is taken.
//   Reset empties the chain (valid bits cleared), zeroes the current time and
//   sets end_time to all ones. cfg_we_i writes end_time at once, no wait.
module timestamp_event_queue import teq_pkg::*; #(
  parameter int unsigned QueueDepth  = QueueDepthDef,
  parameter int unsigned PayloadBits = PayloadBitsDef,
  localparam int unsigned CountW     = $clog2(QueueDepth + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [StampW-1:0]      cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   kind_i,
  input  logic [StampW-1:0]      stamp_i,
  input  logic [PayloadBits-1:0] payload_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [1:0]             status_o,
  output logic                   out_valid_o,
  output logic [StampW-1:0]      out_stamp_o,
  output logic [PayloadBits-1:0] out_payload_o,
  output logic [StampW-1:0]      now_time_o,
  output logic [CountW-1:0]      fill_o
);

  logic [StampW-1:0]      end_time_q;
  logic [StampW-1:0]      now_time_q, now_time_d;
  logic [CountW-1:0]      count_q, count_d;
  logic                   res_valid_q;
  status_e                res_status_q, res_status_d;
  logic                   res_ovalid_q, res_ovalid_d;
  logic [StampW-1:0]      res_stamp_q, res_stamp_d;
  logic [PayloadBits-1:0] res_payload_q, res_payload_d;

  logic                   accept, full;
  cell_op_t               op;

  logic [StampW-1:0]      stamp_w   [QueueDepth];
  logic [PayloadBits-1:0] payload_w [QueueDepth];
  logic [QueueDepth-1:0]  valid_w;
  logic [QueueDepth-1:0]  ge_w;

  assign in_ready_o = !res_valid_q || res_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CountW'(QueueDepth));
  assign op.ins     = accept && !kind_i && !full;
  assign op.rem     = accept && kind_i && valid_w[0];

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic                   l_ge, l_valid, r_valid;
    logic [StampW-1:0]      l_stamp, r_stamp;
    logic [PayloadBits-1:0] l_payload, r_payload;

    if (i == 0) begin : g_head
      assign l_ge      = 1'b0;
      assign l_valid   = 1'b0;
      assign l_stamp   = '0;
      assign l_payload = '0;
    end else begin : g_body
      assign l_ge      = ge_w[i-1];
      assign l_valid   = valid_w[i-1];
      assign l_stamp   = stamp_w[i-1];
      assign l_payload = payload_w[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign r_valid   = 1'b0;
      assign r_stamp   = '0;
      assign r_payload = '0;
    end else begin : g_mid
      assign r_valid   = valid_w[i+1];
      assign r_stamp   = stamp_w[i+1];
      assign r_payload = payload_w[i+1];
    end

    teq_cell #(
      .PayloadBits(PayloadBits)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .op_i           (op),
      .new_stamp_i    (stamp_i),
      .new_payload_i  (payload_i),
      .left_ge_i      (l_ge),
      .left_stamp_i   (l_stamp),
      .left_payload_i (l_payload),
      .left_valid_i   (l_valid),
      .right_stamp_i  (r_stamp),
      .right_payload_i(r_payload),
      .right_valid_i  (r_valid),
      .stamp_o        (stamp_w[i]),
      .payload_o      (payload_w[i]),
      .valid_o        (valid_w[i]),
      .ge_o           (ge_w[i])
    );
  end

  always_comb begin
    now_time_d    = now_time_q;
    count_d       = count_q;
    res_status_d  = ST_OK;
    res_ovalid_d  = 1'b0;
    res_stamp_d   = '0;
    res_payload_d = '0;
    if (!kind_i) begin
      if (full) begin
        res_status_d = ST_FULL;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end else if (!valid_w[0]) begin
      res_status_d = ST_EMPTY;
    end else begin
      res_stamp_d   = stamp_w[0];
      res_payload_d = payload_w[0];
      now_time_d    = stamp_w[0];
      count_d       = count_q - CountW'(1);
      if (stamp_w[0] > end_time_q) begin
        res_status_d = ST_PAST_END;
      end else begin
        res_ovalid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_time_q  <= '1;
      now_time_q  <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        end_time_q <= cfg_wdata_i;
      end
      if (accept) begin
        now_time_q  <= now_time_d;
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q  <= res_status_d;
      res_ovalid_q  <= res_ovalid_d;
      res_stamp_q   <= res_stamp_d;
      res_payload_q <= res_payload_d;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign status_o      = res_status_q;
  assign out_valid_o   = res_ovalid_q;
  assign out_stamp_o   = res_stamp_q;
  assign out_payload_o = res_payload_q;
  assign now_time_o    = now_time_q;
  assign fill_o        = count_q;

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == 32'(count_q))
    else $error("fill count disagrees with chain");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QueueDepth))
    else $error("fill count overflow");
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !kind_i && full |=> res_status_q == ST_FULL && count_q == $past(count_q))
    else $error("schedule into full queue not dropped");
  a_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.rem |=> now_time_q == $past(stamp_w[0]) && out_stamp_o == $past(stamp_w[0]))
    else $error("current time not taken from head");
`endif

endmodule

@@ src/teq_cell.sv @@
// One slot of the sorted register chain: holds an event and shifts with its neighbors.
module teq_cell import teq_pkg::*; #(
  parameter int unsigned PayloadBits = PayloadBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_op_t               op_i,
  input  logic [StampW-1:0]      new_stamp_i,
  input  logic [PayloadBits-1:0] new_payload_i,
  input  logic                   left_ge_i,
  input  logic [StampW-1:0]      left_stamp_i,
  input  logic [PayloadBits-1:0] left_payload_i,
  input  logic                   left_valid_i,
  input  logic [StampW-1:0]      right_stamp_i,
  input  logic [PayloadBits-1:0] right_payload_i,
  input  logic                   right_valid_i,
  output logic [StampW-1:0]      stamp_o,
  output logic [PayloadBits-1:0] payload_o,
  output logic                   valid_o,
  output logic                   ge_o
);

  logic [StampW-1:0]      stamp_q, stamp_d;
  logic [PayloadBits-1:0] payload_q, payload_d;
  logic                   valid_q, valid_d;
  logic                   take_new, take_left;

  // ge: this slot is empty or holds a stamp at or after the new one
  assign ge_o      = !valid_q || (stamp_q >= new_stamp_i);
  assign take_new  = op_i.ins && ge_o && !left_ge_i;
  assign take_left = op_i.ins && ge_o && left_ge_i;

  always_comb begin
    stamp_d   = stamp_q;
    payload_d = payload_q;
    valid_d   = valid_q;
    if (op_i.rem) begin
      stamp_d   = right_stamp_i;
      payload_d = right_payload_i;
      valid_d   = right_valid_i;
    end else if (take_new) begin
      stamp_d   = new_stamp_i;
      payload_d = new_payload_i;
      valid_d   = 1'b1;
    end else if (take_left) begin
      stamp_d   = left_stamp_i;
      payload_d = left_payload_i;
      valid_d   = left_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q   <= stamp_d;
    payload_q <= payload_d;
  end

  assign stamp_o   = stamp_q;
  assign payload_o = payload_q;
  assign valid_o   = valid_q;

`ifndef SYNTHESIS
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && right_valid_i |-> stamp_q <= right_stamp_i)
    else $error("chain out of order");
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_valid_i |-> valid_q)
    else $error("gap in chain");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(op_i.ins && op_i.rem))
    else $error("insert and remove together");
`endif

endmodule
